@@ design/mpw_pkg.sv @@
// Shared types, constants and lookup functions for the mecanum polar H-bridge PWM block.
// Used by the CORDIC cell, the result slot cell and the top level; no dependencies.
package mpw_pkg;

  // Sizes
  localparam int CORDIC_STAGES = 16;   // rotation cells per sine lane, 12..20
  localparam int MOTORS        = 4;
  localparam int STG_W         = 5;    // bits of a cell's stage number (table has 20 rows)
  localparam int X_W           = 34;   // CORDIC x/y, Q2.30 with headroom
  localparam int Z_W           = 33;   // CORDIC angle residual, 2^32 units per turn

  // Fixed values
  localparam logic signed [X_W-1:0] CORDIC_X0 = 34'sd652032874;  // 1/gain in Q2.30
  localparam logic [14:0] FULL_Q8   = 15'd25600;                 // 100 percent in Q8
  localparam logic [15:0] PWM_RESET = 16'd999;
  localparam logic [23:0] RECIP_100 = 24'd10737419;              // ceil(2^30 / 100)

  // Command codes
  typedef enum logic [1:0] {
    OP_POLAR     = 2'd0,
    OP_SET_ONE   = 2'd1,
    OP_SET_ALL   = 2'd2,
    OP_BRAKE_ALL = 2'd3
  } op_t;

  // H-bridge drive codes
  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_BWD   = 2'd2,
    DIR_BRAKE = 2'd3
  } dir_t;

  // One CORDIC lane as it moves from cell to cell
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } lane_t;

  // One motor result waiting for its compare values
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [1:0]  motor;
    dir_t        dir;
    logic [14:0] mag;
  } slot_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] cordic_atan(input logic [STG_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = 33'sd536870912;
      5'd1:    a = 33'sd316933406;
      5'd2:    a = 33'sd167458907;
      5'd3:    a = 33'sd85004756;
      5'd4:    a = 33'sd42667331;
      5'd5:    a = 33'sd21354465;
      5'd6:    a = 33'sd10679838;
      5'd7:    a = 33'sd5340245;
      5'd8:    a = 33'sd2670163;
      5'd9:    a = 33'sd1335087;
      5'd10:   a = 33'sd667544;
      5'd11:   a = 33'sd333772;
      5'd12:   a = 33'sd166886;
      5'd13:   a = 33'sd83443;
      5'd14:   a = 33'sd41722;
      5'd15:   a = 33'sd20861;
      5'd16:   a = 33'sd10430;
      5'd17:   a = 33'sd5215;
      5'd18:   a = 33'sd2608;
      5'd19:   a = 33'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/mpw_cordic_cell.sv @@
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on mpw_pkg for the lane type and the arctangent table.
module mpw_cordic_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [mpw_pkg::STG_W-1:0] stage,
  input  mpw_pkg::lane_t            lane_i,
  output mpw_pkg::lane_t            lane_o
);
  import mpw_pkg::*;

  lane_t                 lane_r;
  lane_t                 lane_nxt;
  logic signed [X_W-1:0] xi;
  logic signed [X_W-1:0] yi;
  logic signed [X_W-1:0] xs;
  logic signed [X_W-1:0] ys;
  logic signed [Z_W-1:0] zi;
  logic signed [Z_W-1:0] at;

  // Rotate toward zero residual angle
  always_comb begin
    xi = lane_i.x;
    yi = lane_i.y;
    zi = lane_i.z;
    xs = xi >>> stage;
    ys = yi >>> stage;
    at = cordic_atan(stage);
    if (!zi[Z_W-1]) begin
      lane_nxt.x = xi - ys;
      lane_nxt.y = yi + xs;
      lane_nxt.z = zi - at;
    end else begin
      lane_nxt.x = xi + ys;
      lane_nxt.y = yi - xs;
      lane_nxt.z = zi + at;
    end
  end

  // Hand the lane to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

@@ design/mpw_slot_cell.sv @@
// One slot of the result queue: loads from the command stage or takes its upper neighbor.
// Depends on mpw_pkg for the slot type.
module mpw_slot_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            shift,
  input  mpw_pkg::slot_t  load_d,
  input  mpw_pkg::slot_t  nb_d,
  output mpw_pkg::slot_t  slot_d
);
  import mpw_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  // Load a fresh command, else advance toward the output
  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = load_d;
    end else if (shift) begin
      slot_nxt = nb_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_d = slot_r;

endmodule

@@ design/mecanum_polar_hbridge_pwm.sv @@
// Mecanum drive command block: polar inverse kinematics and H-bridge compare values.
// Depends on mpw_pkg, mpw_cordic_cell and mpw_slot_cell.
//
// Each accepted command yields one result per motor it updates, in motor order, with
// out_tlast on the final one: four for polar move, set all and brake all, one for set one,
// none for set one with a motor index of 4 or more. A command passes a front stage, two
// parallel CORDIC chains of CORDIC_STAGES cells (one per sine), three stages of rounding,
// scaling and decoding, then loads a row of four result slots; from there the results
// go one per cycle, while the output is not stalled, through two multiplier stages to the
// output register. The single result port sets the pace: a command occupies it for as
// many results as it yields, and a new command loads into the slots in the same cycle
// that the last slot of the previous one leaves. in_tready drops only while a decoded
// command waits for the slots.
module mecanum_polar_hbridge_pwm (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: pwm_max
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, low bit up: motor_index[2:0], direction[4:3], angle[20:5], speed_first[36:21],
  // speed_second[52:37], speed_third[68:53], speed_fourth[84:69], zero pad[87:85]
  input  logic [87:0] in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, low bit up: motor_out[1:0], drive_direction[3:2], speed_applied[18:4],
  // compare_forward[34:19], compare_backward[50:35], zero pad[55:51]
  output logic [55:0] out_tdata,
  output logic        out_tlast
);
  import mpw_pkg::*;

  typedef struct packed {
    op_t                          op;
    logic [2:0]                   idx;
    dir_t                         dir;
    logic [MOTORS-1:0][15:0]      spd;
  } cmd_t;

  typedef struct packed {
    logic                  neg;
    logic signed [Z_W-1:0] z;
  } fold_t;

  typedef struct packed {
    logic        last;
    logic [1:0]  motor;
    dir_t        dir;
    logic [14:0] mag;
    logic [15:0] cf;
    logic [15:0] cb;
  } res_t;

  localparam logic signed [X_W-1:0] Y_HALF   = 34'sd16384;
  localparam logic signed [X_W-1:0] SAT_HI   = 34'sd32767;
  localparam logic signed [X_W-1:0] SAT_LO   = -34'sd32768;
  localparam logic signed [17:0]    FULL_W   = 18'sd25600;
  localparam logic signed [32:0]    TRUNC_UP = 33'sd32767;
  localparam logic [15:0]           QTR      = 16'd8192;
  localparam logic [15:0]           FOLD_LO  = 16'd16384;
  localparam logic [15:0]           FOLD_HI  = 16'd49152;
  localparam logic signed [16:0]    HALF_T   = 17'sd32768;

  // Fold a heading into [-1/4, 1/4) turn; z in 2^-32 turn units
  function automatic fold_t fold_angle(input logic [15:0] u);
    fold_t            f;
    logic signed [16:0] t;
    if (u >= FOLD_LO && u < FOLD_HI) begin
      t     = $signed({1'b0, u}) - HALF_T;
      f.neg = 1'b1;
    end else begin
      t     = $signed({u[15], u});
      f.neg = 1'b0;
    end
    f.z = Z_W'(t) <<< 16;
    return f;
  endfunction

  // Round Q2.30 to Q1.15, saturate, undo the fold
  function automatic logic signed [16:0] sine_round(input logic signed [X_W-1:0] y,
                                                    input logic neg);
    logic signed [X_W-1:0] yr;
    logic signed [16:0]    s;
    yr = (y + Y_HALF) >>> 15;
    if (yr > SAT_HI) begin
      s = 17'sd32767;
    end else if (yr < SAT_LO) begin
      s = -17'sd32768;
    end else begin
      s = yr[16:0];
    end
    return neg ? -s : s;
  endfunction

  // Signed wheel speed to direction and clamped magnitude
  function automatic slot_t drive_signed(input logic signed [17:0] w);
    slot_t              d;
    logic signed [17:0] nw;
    d  = '0;
    nw = -w;
    if (w > 18'sd0) begin
      d.dir = DIR_FWD;
      d.mag = (w > FULL_W) ? FULL_Q8 : w[14:0];
    end else if (w < 18'sd0) begin
      d.dir = DIR_BWD;
      d.mag = (nw > FULL_W) ? FULL_Q8 : nw[14:0];
    end else begin
      d.dir = DIR_STOP;
      d.mag = '0;
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake control
  logic              cmd_adv;
  logic              res_adv;
  logic              pop;
  logic              load_ok;
  logic              load;
  logic [MOTORS-1:0] sv;
  logic [MOTORS-1:0] slot_last;
  logic [MOTORS:0]   sv_inc;

  // ---------------------------------------------------------------------------
  // Configuration register
  logic [15:0] pwm_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_max_r <= PWM_RESET;
    end else if (cfg_wr_en) begin
      pwm_max_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Front stage: unpack the request and fold both headings
  cmd_t  in_cmd;
  fold_t fa;
  fold_t fb;
  logic [15:0] angle;

  always_comb begin
    in_cmd.op  = op_t'(in_tuser);
    in_cmd.idx = in_tdata[2:0];
    in_cmd.dir = dir_t'(in_tdata[4:3]);
    angle      = in_tdata[20:5];
    for (int k = 0; k < MOTORS; k++) begin
      in_cmd.spd[k] = in_tdata[21 + 16*k +: 16];
    end
    fa = fold_angle(angle + QTR);
    fb = fold_angle(angle - QTR);
  end

  logic [CORDIC_STAGES:0] cv_r;
  cmd_t                   ccmd_r [CORDIC_STAGES+1];
  logic [1:0]             cneg_r [CORDIC_STAGES+1];   // {lane a, lane b}
  lane_t                  front_a_r;
  lane_t                  front_b_r;
  lane_t                  la_o [CORDIC_STAGES];
  lane_t                  lb_o [CORDIC_STAGES];

  // Advance the valid line beside the cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (cmd_adv) begin
      cv_r <= {cv_r[CORDIC_STAGES-1:0], in_tvalid};
    end
  end

  // Advance command fields and fold flags beside the cells
  always_ff @(posedge clk) begin
    if (cmd_adv) begin
      ccmd_r[0]   <= in_cmd;
      cneg_r[0]   <= {fa.neg, fb.neg};
      front_a_r.x <= CORDIC_X0;
      front_a_r.y <= '0;
      front_a_r.z <= fa.z;
      front_b_r.x <= CORDIC_X0;
      front_b_r.y <= '0;
      front_b_r.z <= fb.z;
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        ccmd_r[k] <= ccmd_r[k-1];
        cneg_r[k] <= cneg_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC chains, one per sine
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    lane_t a_in;
    lane_t b_in;
    if (g == 0) begin : g_first
      assign a_in = front_a_r;
      assign b_in = front_b_r;
    end else begin : g_next
      assign a_in = la_o[g-1];
      assign b_in = lb_o[g-1];
    end
    mpw_cordic_cell u_cell_a (
      .clk    (clk),
      .en     (cmd_adv),
      .stage  (STG_W'(g)),
      .lane_i (a_in),
      .lane_o (la_o[g])
    );
    mpw_cordic_cell u_cell_b (
      .clk    (clk),
      .en     (cmd_adv),
      .stage  (STG_W'(g)),
      .lane_i (b_in),
      .lane_o (lb_o[g])
    );
  end

  // ---------------------------------------------------------------------------
  // P1: round the sines; P2: scale by the polar speed
  logic               p1_valid_r;
  cmd_t               p1_cmd_r;
  logic signed [16:0] p1_sa_r;
  logic signed [16:0] p1_sb_r;
  logic               p2_valid_r;
  cmd_t               p2_cmd_r;
  logic signed [32:0] p2_pa_r;
  logic signed [32:0] p2_pb_r;
  logic signed [15:0] p1_s0;

  assign p1_s0 = $signed(p1_cmd_r.spd[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (cmd_adv) begin
      p1_valid_r <= cv_r[CORDIC_STAGES];
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_adv) begin
      p1_cmd_r <= ccmd_r[CORDIC_STAGES];
      p1_sa_r  <= sine_round(la_o[CORDIC_STAGES-1].y, cneg_r[CORDIC_STAGES][1]);
      p1_sb_r  <= sine_round(lb_o[CORDIC_STAGES-1].y, cneg_r[CORDIC_STAGES][0]);
      p2_cmd_r <= p1_cmd_r;
      p2_pa_r  <= 33'(p1_s0) * 33'(p1_sa_r);
      p2_pb_r  <= 33'(p1_s0) * 33'(p1_sb_r);
    end
  end

  // ---------------------------------------------------------------------------
  // P3: decode the command into per-motor results
  logic signed [32:0] ta;
  logic signed [32:0] tb;
  logic signed [32:0] qa;
  logic signed [32:0] qb;
  logic signed [17:0] w [MOTORS];
  logic signed [15:0] s_one;
  slot_t              dec [MOTORS];
  logic [MOTORS-1:0]  dv;
  logic [MOTORS-1:0]  dv_up;

  always_comb begin
    // truncate toward zero
    ta = p2_pa_r[32] ? p2_pa_r + TRUNC_UP : p2_pa_r;
    tb = p2_pb_r[32] ? p2_pb_r + TRUNC_UP : p2_pb_r;
    qa = ta >>> 15;
    qb = tb >>> 15;
    w[0] = -qb[17:0];
    w[1] = qa[17:0];
    w[2] = qb[17:0];
    w[3] = -qa[17:0];
    s_one = $signed(p2_cmd_r.spd[0]);
    for (int k = 0; k < MOTORS; k++) begin
      dec[k] = '0;
    end
    unique case (p2_cmd_r.op)
      OP_POLAR: begin
        for (int k = 0; k < MOTORS; k++) begin
          dec[k] = drive_signed(w[k]);
          dec[k].motor = 2'(k);
          dec[k].valid = 1'b1;
        end
      end
      OP_SET_ONE: begin
        dec[0].motor = p2_cmd_r.idx[1:0];
        dec[0].dir   = p2_cmd_r.dir;
        dec[0].valid = (p2_cmd_r.idx < 3'(MOTORS));
        if (s_one[15] || p2_cmd_r.dir == DIR_STOP) begin
          dec[0].mag = '0;
        end else if (s_one > $signed({1'b0, FULL_Q8})) begin
          dec[0].mag = FULL_Q8;
        end else begin
          dec[0].mag = s_one[14:0];
        end
      end
      OP_SET_ALL: begin
        for (int k = 0; k < MOTORS; k++) begin
          dec[k] = drive_signed(18'($signed(p2_cmd_r.spd[k])));
          dec[k].motor = 2'(k);
          dec[k].valid = 1'b1;
        end
      end
      OP_BRAKE_ALL: begin
        for (int k = 0; k < MOTORS; k++) begin
          dec[k].motor = 2'(k);
          dec[k].dir   = DIR_BRAKE;
          dec[k].mag   = FULL_Q8;
          dec[k].valid = 1'b1;
        end
      end
    endcase
    // mark the highest valid result as last
    for (int k = 0; k < MOTORS; k++) begin
      dv[k] = dec[k].valid;
    end
    dv_up = {1'b0, dv[MOTORS-1:1]};
    for (int k = 0; k < MOTORS; k++) begin
      dec[k].last = dv[k] & ~dv_up[k];
    end
  end

  logic  p3_valid_r;
  slot_t p3_slot_r [MOTORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (cmd_adv) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_adv) begin
      for (int k = 0; k < MOTORS; k++) begin
        p3_slot_r[k] <= dec[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result slots: a row of cells drained from slot 0
  slot_t slot_q [MOTORS];

  for (genvar g = 0; g < MOTORS; g++) begin : g_slot
    slot_t nb;
    if (g == MOTORS - 1) begin : g_top
      assign nb = '0;
    end else begin : g_mid
      assign nb = slot_q[g+1];
    end
    mpw_slot_cell u_slot (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (load),
      .shift  (pop),
      .load_d (p3_slot_r[g]),
      .nb_d   (nb),
      .slot_d (slot_q[g])
    );
    assign sv[g]        = slot_q[g].valid;
    assign slot_last[g] = slot_q[g].last;
  end

  // Load when the slots are empty, or when only slot 0 is busy and it leaves this cycle
  assign res_adv   = !out_tvalid || out_tready;
  assign pop       = sv[0] && res_adv;
  assign load_ok   = !sv[1] && (!sv[0] || pop);
  assign load      = p3_valid_r && load_ok;
  assign cmd_adv   = !p3_valid_r || load_ok;
  assign in_tready = cmd_adv;
  assign sv_inc    = {1'b0, sv} + (MOTORS+1)'(1);

  // ---------------------------------------------------------------------------
  // Compare value: floor(mag * pwm_max / 25600) as >> 8, then * ceil(2^30/100) >> 30
  logic        r1_valid_r;
  slot_t       r1_slot_r;
  logic [30:0] r1_prod_r;
  logic        r2_valid_r;
  slot_t       r2_slot_r;
  logic [46:0] r2_prod_r;
  logic        out_valid_r;
  res_t        out_r;
  res_t        out_nxt;
  logic [15:0] pwm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r  <= 1'b0;
      r2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (res_adv) begin
      r1_valid_r  <= pop;
      r2_valid_r  <= r1_valid_r;
      out_valid_r <= r2_valid_r;
    end
  end

  // Set the compare pair by drive direction
  always_comb begin
    pwm           = r2_prod_r[45:30];
    out_nxt.last  = r2_slot_r.last;
    out_nxt.motor = r2_slot_r.motor;
    out_nxt.dir   = r2_slot_r.dir;
    out_nxt.mag   = r2_slot_r.mag;
    out_nxt.cf    = '0;
    out_nxt.cb    = '0;
    unique case (r2_slot_r.dir)
      DIR_FWD:   out_nxt.cf = pwm;
      DIR_BWD:   out_nxt.cb = pwm;
      DIR_BRAKE: begin
        out_nxt.cf = pwm;
        out_nxt.cb = pwm;
      end
      DIR_STOP:  out_nxt.mag = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_adv) begin
      r1_slot_r <= slot_q[0];
      r1_prod_r <= 31'(slot_q[0].mag) * 31'(pwm_max_r);
      r2_slot_r <= r1_slot_r;
      r2_prod_r <= 47'(r1_prod_r[30:8]) * 47'(RECIP_100);
      out_r     <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {5'b0, out_r.cb, out_r.cf, out_r.mag, out_r.dir, out_r.motor};

  // ---------------------------------------------------------------------------
  // Checks
  // slots always fill from slot 0 upward without holes
  a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(sv_inc))
    else $error("result slots not packed toward slot 0");

  // at most one queued result carries last
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(slot_last & sv))
    else $error("more than one queued result marked last");

  // commands stall only behind a decoded command that waits for busy slots
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> p3_valid_r && (sv[0] || sv[1]))
    else $error("command channel stalled without a waiting command");

  // a stopped motor gets zero drive; speed never exceeds full scale
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_r.mag <= FULL_Q8) &&
                   (out_r.dir != DIR_STOP ||
                    (out_r.cf == 16'd0 && out_r.cb == 16'd0 && out_r.mag == 15'd0)))
    else $error("result drive values out of range");

endmodule

@@ test/mecanum_polar_hbridge_pwm_tb.sv @@
// Self-checking bench for mecanum_polar_hbridge_pwm: directed and random commands, stalls on both
// streams, pwm_max swept between phases. Results are predicted per command and compared in order.
// Depends on mpw_pkg and the mecanum_polar_hbridge_pwm RTL.
module mecanum_polar_hbridge_pwm_tb;
  import mpw_pkg::*;

  localparam int DRAIN_PAUSE = CORDIC_STAGES + 24;
  localparam int LONG_HOLD   = 250;

  // One command as the sender offers it
  typedef struct packed {
    op_t             op;
    logic [2:0]      idx;
    logic [1:0]      dir;
    logic [15:0]     angle;
    logic [3:0][15:0] spd;
  } cmd_t;

  // One motor drive result
  typedef struct packed {
    logic [1:0]  motor;
    dir_t        dir;
    logic [14:0] mag;
    logic [15:0] cmp_fwd;
    logic [15:0] cmp_bwd;
    logic        last;
  } drive_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;

  // Bench state
  cmd_t       cmd_queue[$];
  drive_res_t pending_drives[$];
  cmd_t       cur_cmd;
  bit         cmd_taken;
  int         gap_left;
  int         tx_mode_left;
  bit         tx_burst;
  int         rx_gap;
  int         rx_mode_left;
  bit         rx_burst;
  int         hold_left;
  bit         long_hold_done;
  int         results_seen;
  int         err_count;

  // Predictor copy of the block's register and motor state
  logic [15:0] pwm_model;
  dir_t        dir_track [4];
  logic [14:0] speed_track [4];
  longint      atan_turn [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  mecanum_polar_hbridge_pwm uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Sine of a binary-turn heading in Q1.15 via rotation CORDIC
  function automatic int sine_q15(input logic [15:0] turn);
    int     t;
    int     i;
    bit     neg;
    longint x;
    longint y;
    longint z;
    longint nx;
    t   = turn;
    neg = 1'b0;
    x   = 652032874;
    y   = 0;
    // fold the left half plane onto the right one
    if (t >= 16384 && t < 49152) begin
      t   = t - 32768;
      neg = 1'b1;
    end else if (t >= 49152) begin
      t = t - 65536;
    end
    z = longint'(t) * 65536;
    for (i = 0; i < CORDIC_STAGES && i < 20; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_turn[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_turn[i];
      end
      x = nx;
    end
    y = (y + 16384) >>> 15;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return neg ? -int'(y) : int'(y);
  endfunction

  // Clamp a speed, set the bridge compare pair and record the motor state
  function automatic drive_res_t motor_drive(input int m, input dir_t d, input int spd,
                                             input bit last);
    drive_res_t r;
    longint     pwm;
    int         mag;
    mag = spd;
    if (mag < 0) mag = 0;
    if (mag > 25600) mag = 25600;
    pwm = (longint'(mag) * longint'(pwm_model)) / 25600;
    r.motor   = m[1:0];
    r.dir     = d;
    r.cmp_fwd = '0;
    r.cmp_bwd = '0;
    r.last    = last;
    case (d)
      DIR_FWD: begin
        r.cmp_fwd = pwm[15:0];
      end
      DIR_BWD: begin
        r.cmp_bwd = pwm[15:0];
      end
      DIR_BRAKE: begin
        r.cmp_fwd = pwm[15:0];
        r.cmp_bwd = pwm[15:0];
      end
      default: begin
        mag = 0;
      end
    endcase
    r.mag = mag[14:0];
    dir_track[m]   = d;
    speed_track[m] = r.mag;
    return r;
  endfunction

  // Map a signed wheel speed onto forward, backward or stop
  function automatic drive_res_t signed_drive(input int m, input int s, input bit last);
    if (s > 0) return motor_drive(m, DIR_FWD, s, last);
    if (s < 0) return motor_drive(m, DIR_BWD, -s, last);
    return motor_drive(m, DIR_STOP, 0, last);
  endfunction

  // Queue the results an accepted command must produce
  task automatic predict_command(input cmd_t c);
    int sa;
    int sb;
    int s0;
    int w [4];
    int m;
    s0 = int'($signed(c.spd[0]));
    case (c.op)
      OP_POLAR: begin
        sa = (s0 * sine_q15(c.angle + 16'd8192)) / 32768;
        sb = (s0 * sine_q15(c.angle - 16'd8192)) / 32768;
        w[0] = -sb;
        w[1] = sa;
        w[2] = sb;
        w[3] = -sa;
        for (m = 0; m < 4; m++) pending_drives.push_back(signed_drive(m, w[m], m == 3));
      end
      OP_SET_ONE: begin
        // drop commands aimed at a motor that does not exist
        if (c.idx < 3'd4)
          pending_drives.push_back(motor_drive(int'(c.idx), dir_t'(c.dir), s0, 1'b1));
      end
      OP_SET_ALL: begin
        for (m = 0; m < 4; m++)
          pending_drives.push_back(signed_drive(m, int'($signed(c.spd[m])), m == 3));
      end
      default: begin
        for (m = 0; m < 4; m++)
          pending_drives.push_back(motor_drive(m, DIR_BRAKE, 25600, m == 3));
      end
    endcase
  endtask

  function automatic cmd_t mk_cmd(input op_t op, input int idx, input dir_t d, input int angle,
                                  input int s0, input int s1, input int s2, input int s3);
    cmd_t c;
    c.op     = op;
    c.idx    = idx[2:0];
    c.dir    = d;
    c.angle  = angle[15:0];
    c.spd[0] = s0[15:0];
    c.spd[1] = s1[15:0];
    c.spd[2] = s2[15:0];
    c.spd[3] = s3[15:0];
    return c;
  endfunction

  // Speeds: full range, the usable range, and the clamp edges
  function automatic logic [15:0] rand_speed();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom);
    if (r < 7) return 16'(int'($urandom_range(0, 51200)) - 25600);
    case ($urandom_range(0, 8))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      3: return 16'd25600;
      4: return 16'(-25600);
      5: return 16'd25601;
      6: return 16'(-25601);
      7: return 16'h7fff;
      default: return 16'h8000;
    endcase
  endfunction

  // Random command with all unused fields filled at random
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    int   m;
    r = $urandom_range(0, 99);
    if (r < 35) c.op = OP_POLAR;
    else if (r < 62) c.op = OP_SET_ONE;
    else if (r < 87) c.op = OP_SET_ALL;
    else c.op = OP_BRAKE_ALL;
    c.idx = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    c.dir = 2'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 7))
        0: c.angle = 16'd0;
        1: c.angle = 16'd8192;
        2: c.angle = 16'd16383;
        3: c.angle = 16'd16384;
        4: c.angle = 16'd32768;
        5: c.angle = 16'd49151;
        6: c.angle = 16'd49152;
        default: c.angle = 16'hffff;
      endcase
    end else begin
      c.angle = 16'($urandom);
    end
    for (m = 0; m < 4; m++) c.spd[m] = rand_speed();
    return c;
  endfunction

  // Idle lengths: mostly none or short, a few long
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input drive_res_t e, input drive_res_t g);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: exp motor %0d dir %0d mag %0d fwd %0d bwd %0d last %0d",
               what, e.motor, e.dir, e.mag, e.cmp_fwd, e.cmp_bwd, e.last);
      $display("  got motor %0d dir %0d mag %0d fwd %0d bwd %0d last %0d",
               g.motor, g.dir, g.mag, g.cmp_fwd, g.cmp_bwd, g.last);
    end
  endtask

  // Sender: hold a request until taken, then idle or offer the next one
  always @(negedge clk) begin
    logic nv;
    nv = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_tvalid && !cmd_taken) begin
      nv = 1'b1;
    end else begin
      cmd_taken = 1'b0;
      if (tx_mode_left == 0) begin
        tx_burst     = ($urandom_range(0, 3) == 0);
        tx_mode_left = $urandom_range(20, 80);
      end else begin
        tx_mode_left--;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_queue.size() > 0) begin
        cur_cmd  = cmd_queue.pop_front();
        in_tdata <= {3'b000, cur_cmd.spd[3], cur_cmd.spd[2], cur_cmd.spd[1], cur_cmd.spd[0],
                     cur_cmd.angle, cur_cmd.dir, cur_cmd.idx};
        in_tuser <= cur_cmd.op;
        nv       = 1'b1;
        gap_left = pick_gap(tx_burst);
      end
    end
    in_tvalid <= nv;
  end

  // Receiver: random stalls plus one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 120) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      out_tready     <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_burst     = ($urandom_range(0, 3) == 0);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap(rx_burst);
      end
    end
  end

  // Sample at the rising edge: register writes, accepted requests, accepted results
  always @(posedge clk) begin
    drive_res_t e;
    drive_res_t g;
    if (rst_n) begin
      if (cfg_wr_en) pwm_model = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        cmd_taken = 1'b1;
        predict_command(cur_cmd);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        g.motor   = out_tdata[1:0];
        g.dir     = dir_t'(out_tdata[3:2]);
        g.mag     = out_tdata[18:4];
        g.cmp_fwd = out_tdata[34:19];
        g.cmp_bwd = out_tdata[50:35];
        g.last    = out_tlast;
        if (pending_drives.size() == 0) begin
          report_mismatch("unexpected result", '0, g);
        end else begin
          e = pending_drives.pop_front();
          if (g.motor !== e.motor || g.dir !== e.dir || g.mag !== e.mag ||
              g.cmp_fwd !== e.cmp_fwd || g.cmp_bwd !== e.cmp_bwd || g.last !== e.last)
            report_mismatch("mismatch", e, g);
        end
      end
    end
  end

  // Wait until every request is taken and every result is back, then let the pipe drain
  task automatic wait_idle();
    while (!(cmd_queue.size() == 0 && !in_tvalid && pending_drives.size() == 0))
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_pwm(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stimulus: directed commands, then random phases across pwm_max settings
  initial begin
    logic [15:0] pwm_steps [6];
    int          ph;
    int          n;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cmd_taken      = 1'b0;
    gap_left       = 0;
    tx_mode_left   = 0;
    tx_burst       = 1'b0;
    rx_gap         = 0;
    rx_mode_left   = 0;
    rx_burst       = 1'b0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    results_seen   = 0;
    err_count      = 0;
    pwm_model      = PWM_RESET;
    for (n = 0; n < 4; n++) begin
      dir_track[n]   = DIR_STOP;
      speed_track[n] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: brake all, clamp edges, every set-one direction, bad indexes, quadrant edges
    cmd_queue.push_back(mk_cmd(OP_BRAKE_ALL, 5, DIR_FWD, 'h1234, 'h7fff, 'h8000, 77, -9));
    cmd_queue.push_back(mk_cmd(OP_SET_ALL, 6, DIR_BRAKE, 'hffff, 32767, -32768, 0, 1));
    cmd_queue.push_back(mk_cmd(OP_SET_ALL, 0, DIR_STOP, 0, 25600, -25600, 25601, -1));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 0, DIR_FWD, 'hbeef, 12800, 5, 6, 7));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 1, DIR_BWD, 0, 25600, -1, -1, -1));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 2, DIR_BRAKE, 100, 30000, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 3, DIR_STOP, 200, 5000, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 0, DIR_FWD, 0, -100, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 1, DIR_BRAKE, 0, -32768, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 4, DIR_FWD, 0, 12000, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 7, DIR_BRAKE, 'hffff, 'h7fff, 'h7fff, 'h7fff, 1));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 3, DIR_STOP, 0, 25600, 11, 22, 33));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 0, DIR_BWD, 16384, 32767, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 7, DIR_BRAKE, 32768, -32768, -1, -1, -1));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 1, DIR_FWD, 49152, 25600, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 2, DIR_STOP, 65535, -25600, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 0, DIR_STOP, 8192, 32767, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 0, DIR_STOP, 57344, 100, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_POLAR, 0, DIR_STOP, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ONE, 2, DIR_FWD, 0, 32767, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(OP_SET_ALL, 0, DIR_STOP, 0, 0, 0, 0, 0));
    for (n = 0; n < 40; n++) cmd_queue.push_back(rand_cmd());
    wait_idle();

    // sweep pwm_max, random commands in each setting
    pwm_steps[0] = 16'hffff;
    pwm_steps[1] = 16'd0;
    pwm_steps[2] = 16'd1;
    pwm_steps[3] = 16'($urandom);
    pwm_steps[4] = 16'd25600;
    pwm_steps[5] = PWM_RESET;
    for (ph = 0; ph < 6; ph++) begin
      write_pwm(pwm_steps[ph]);
      for (n = 0; n < 52; n++) cmd_queue.push_back(rand_cmd());
      wait_idle();
    end

    if (err_count == 0 && pending_drives.size() == 0) begin
      $display("mecanum_polar_hbridge_pwm verification clean");
    end else begin
      $display("mecanum_polar_hbridge_pwm verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("mecanum_polar_hbridge_pwm verification failed");
    $finish;
  end

endmodule
